@@ sv/distance_vector_route_update_assert.svh @@
// ----------------------------------------------------------------------------
// Distance-vector route update assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define DVRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication.
`define DVRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define DVRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DVRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/dvru_pkg.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update package
// Shared sizes, codes, payload types and helpers.
// ----------------------------------------------------------------------------
package dvru_pkg;

	localparam int NODES       = 4;
	localparam int COST_FIELDS = 4;
	localparam int NODE_W      = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int COST_W      = 10;
	localparam int ID_W        = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	localparam logic [COST_W-1:0] INF_COST = 10'd999;

	localparam logic CMD_ANNOUNCE = 1'b0;
	localparam logic CMD_UPDATE   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_0  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_1  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_2  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_3  = 3'd4;

	typedef logic [COST_W-1:0] cost_t;

	typedef struct packed {
		logic            command;
		logic [ID_W-1:0] source_node;
		cost_t           cost_0;
		cost_t           cost_1;
		cost_t           cost_2;
		cost_t           cost_3;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0] dest_node;
		cost_t           vec_cost_0;
		cost_t           vec_cost_1;
		cost_t           vec_cost_2;
		cost_t           vec_cost_3;
		logic            last;
	} rsp_t;

	typedef struct packed {
		logic              relax_en;
		logic [NODE_W-1:0] src_idx;
		cost_t             link_src;
	} lane_ctl_t;

	typedef struct packed {
		logic             changed;
		logic [NODES-1:0] nbr_mask;
	} merge_stat_t;

	function automatic cost_t clamp_inf(cost_t v);
		return (v > INF_COST) ? INF_COST : v;
	endfunction

endpackage

@@ sv/dvru_lane.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route lane
// Holds one destination column of the route table; relaxes it and finds the
// column minimum against the own link cost.
// ----------------------------------------------------------------------------
module dvru_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  dvru_pkg::lane_ctl_t ctl,
	input  dvru_pkg::cost_t   cost,
	input  dvru_pkg::cost_t   own_link,
	output logic              changed,
	output dvru_pkg::cost_t   best
);
	import dvru_pkg::*;

	cost_t             col_q [NODES];
	logic [COST_W:0]   sum;

	assign sum     = {1'b0, cost} + {1'b0, ctl.link_src};
	assign changed = ctl.relax_en && (sum < {1'b0, col_q[ctl.src_idx]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++) begin
				col_q[i] <= INF_COST;
			end
		end else if (changed) begin
			col_q[ctl.src_idx] <= sum[COST_W-1:0];
		end
	end

	always_comb begin
		cost_t m;
		m = own_link;
		for (int j = 0; j < NODES; j++) begin
			if (col_q[j] < m) begin
				m = col_q[j];
			end
		end
		best = clamp_inf(m);
	end

endmodule

@@ sv/dvru_merge.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route merge
// Combines lane results into the outgoing vector, the change flag and the
// neighbor mask.
// ----------------------------------------------------------------------------
module dvru_merge (
	input  logic                      lane_chg  [dvru_pkg::NODES],
	input  dvru_pkg::cost_t           lane_best [dvru_pkg::NODES],
	input  dvru_pkg::cost_t           link      [dvru_pkg::COST_FIELDS],
	input  logic [dvru_pkg::ID_W-1:0] node_id,
	input  logic                      announce,
	output dvru_pkg::cost_t           vec       [dvru_pkg::COST_FIELDS],
	output dvru_pkg::merge_stat_t     stat
);
	import dvru_pkg::*;

	always_comb begin
		stat = '0;
		for (int d = 0; d < COST_FIELDS; d++) begin
			vec[d] = INF_COST;
		end
		for (int d = 0; d < NODES; d++) begin
			vec[d] = announce ? clamp_inf(link[d]) : lane_best[d];
			if (lane_chg[d]) begin
				stat.changed = 1'b1;
			end
			// a neighbor is any other node with a finite link
			stat.nbr_mask[d] = (node_id != ID_W'(d)) && (link[d] < INF_COST);
		end
	end

endmodule

@@ sv/distance_vector_route_update.sv @@
// ----------------------------------------------------------------------------
// Distance-vector route update
// One routing node: relaxes its route table from neighbor vectors and sends
// its own distance vector to every neighbor.
// ----------------------------------------------------------------------------
// An announce request sends the configured link-cost vector to each neighbor;
// an update request relaxes the sender's row of the 4x4 route table and, when
// any entry dropped, sends each neighbor the new minimum vector. One request
// is worked at a time: the accept in IDLE, the RELAX state that relaxes the table
// (all destination lanes in parallel), the MIN state that takes the column
// minima, then the SEND state, which loads the output register once per
// neighbor. An update that changes nothing returns to idle from RELAX, and a
// request that finds no neighbor leaves SEND without a load. A stalled output
// register holds SEND at each load until it is free. The output register lets
// the next request enter while the last vector waits.
// Neighbors get vectors in increasing node order, last set on the final one.
// ----------------------------------------------------------------------------
`include "distance_vector_route_update_assert.svh"

module distance_vector_route_update (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dvru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dvru_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  dvru_pkg::req_t                  cmd,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output dvru_pkg::rsp_t                  rsp
);
	import dvru_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RELAX = 2'd1;
	localparam logic [1:0] ST_MIN   = 2'd2;
	localparam logic [1:0] ST_SEND  = 2'd3;

	// configuration
	logic [ID_W-1:0] node_id_q;
	cost_t           link_q [COST_FIELDS];

	// request in flight and sequencer
	req_t             req_q;
	logic [1:0]       state_q;
	cost_t            vec_q  [COST_FIELDS];
	logic [NODES-1:0] mask_q;

	// output register
	rsp_t rsp_q;
	logic rsp_valid_q;

	// lanes and merge
	cost_t       req_cost  [COST_FIELDS];
	lane_ctl_t   lane_ctl;
	logic        lane_chg  [NODES];
	cost_t       lane_best [NODES];
	cost_t       merge_vec [COST_FIELDS];
	merge_stat_t merge_stat;

	// neighbor pick
	logic [NODES-1:0]  pick_oh;
	logic [NODES-1:0]  mask_rest;
	logic [NODE_W-1:0] pick_idx;
	logic              rsp_free;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
			for (int i = 0; i < COST_FIELDS; i++) begin
				link_q[i] <= INF_COST;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_ID: node_id_q <= cfg_wdata[ID_W-1:0];
				REG_LINK_0:  link_q[0] <= cfg_wdata[COST_W-1:0];
				REG_LINK_1:  link_q[1] <= cfg_wdata[COST_W-1:0];
				REG_LINK_2:  link_q[2] <= cfg_wdata[COST_W-1:0];
				REG_LINK_3:  link_q[3] <= cfg_wdata[COST_W-1:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	assign req_cost[0] = req_q.cost_0;
	assign req_cost[1] = req_q.cost_1;
	assign req_cost[2] = req_q.cost_2;
	assign req_cost[3] = req_q.cost_3;

	// Relax only on an update whose sender lies inside the network.
	assign lane_ctl.relax_en = (state_q == ST_RELAX) && (req_q.command == CMD_UPDATE)
		&& ({1'b0, req_q.source_node} < (ID_W + 1)'(NODES));
	assign lane_ctl.src_idx  = req_q.source_node[NODE_W-1:0];
	assign lane_ctl.link_src = link_q[req_q.source_node];

	for (genvar d = 0; d < NODES; d++) begin : g_lane
		dvru_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (lane_ctl),
			.cost     (req_cost[d]),
			.own_link (link_q[d]),
			.changed  (lane_chg[d]),
			.best     (lane_best[d])
		);
	end

	dvru_merge u_merge (
		.lane_chg  (lane_chg),
		.lane_best (lane_best),
		.link      (link_q),
		.node_id   (node_id_q),
		.announce  (req_q.command == CMD_ANNOUNCE),
		.vec       (merge_vec),
		.stat      (merge_stat)
	);

	// Lowest pending neighbor goes out next.
	always_comb begin
		logic found;
		found    = 1'b0;
		pick_oh  = '0;
		pick_idx = '0;
		for (int k = 0; k < NODES; k++) begin
			if (!found && mask_q[k]) begin
				found      = 1'b1;
				pick_oh[k] = 1'b1;
				pick_idx   = NODE_W'(k);
			end
		end
		mask_rest = mask_q & ~pick_oh;
	end

	// Capture the request payload on accept.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			req_q <= cmd;
		end
	end

	// Hold the minimum vector for the whole send sweep.
	always_ff @(posedge clk) begin
		if (state_q == ST_MIN) begin
			vec_q <= merge_vec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_RELAX;
					end
				end
				ST_RELAX: begin
					// announce always goes on to send; update sends only if the table dropped
					if (req_q.command == CMD_ANNOUNCE || merge_stat.changed) begin
						state_q <= ST_MIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MIN: begin
					mask_q  <= merge_stat.nbr_mask;
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (mask_q == '0) begin
						state_q <= ST_IDLE;
					end else if (rsp_free) begin
						mask_q <= mask_rest;
						if (mask_rest == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic rsp_load;
	assign rsp_load = (state_q == ST_SEND) && (mask_q != '0) && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.dest_node  <= ID_W'(pick_idx);
			rsp_q.vec_cost_0 <= vec_q[0];
			rsp_q.vec_cost_1 <= vec_q[1];
			rsp_q.vec_cost_2 <= vec_q[2];
			rsp_q.vec_cost_3 <= vec_q[3];
			rsp_q.last       <= (mask_rest == '0);
		end
	end

	// Neighbor and range checks on the waiting vector.
	logic rsp_to_nbr;
	logic rsp_in_range;
	assign rsp_to_nbr   = (rsp_q.dest_node != node_id_q)
		&& (link_q[rsp_q.dest_node] < INF_COST);
	assign rsp_in_range = (rsp_q.vec_cost_0 <= INF_COST) && (rsp_q.vec_cost_1 <= INF_COST)
		&& (rsp_q.vec_cost_2 <= INF_COST) && (rsp_q.vec_cost_3 <= INF_COST);

	// A vector only ever goes to a real neighbor.
	`DVRU_ASSERT_IMPL(a_dest_is_neighbor, clk, arst_n, rsp_valid_q, rsp_to_nbr)
	// Sent costs never exceed infinity.
	`DVRU_ASSERT_IMPL(a_cost_bounded, clk, arst_n, rsp_valid_q, rsp_in_range)
	// An accepted request moves straight to relaxation.
	`DVRU_ASSERT_NEXT(a_accept_relax, clk, arst_n, cmd_valid && cmd_ready, state_q == ST_RELAX)
	// The send sweep never loads over a result still waiting.
	`DVRU_ASSERT_IMPL(a_no_overwrite, clk, arst_n, rsp_load, !rsp_valid_q || rsp_ready)

endmodule
